@@ design/rcbt_pkg.sv @@
// Shared types, constants and request token for the relay channel binding table.
package rcbt_pkg;

    localparam int MAX_BINDINGS  = 16;
    localparam int CNT_W         = $clog2(MAX_BINDINGS + 1);
    localparam int ADDR_W        = 48;
    localparam int CHAN_W        = 16;
    localparam int TIME_W        = 48;
    localparam int LIFE_W        = 16;
    localparam int MS_PER_SECOND = 1000;
    localparam int MS_W          = $clog2(MS_PER_SECOND + 1);
    localparam int PROD_W        = LIFE_W + MS_W;
    localparam int LIFE_RESET    = 600;

    typedef enum logic [1:0] {
        OP_BIND        = 2'd0,
        OP_LOOKUP_CH   = 2'd1,
        OP_LOOKUP_PEER = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_REFRESHED = 3'd0,
        ST_ADDED     = 3'd1,
        ST_IN_USE    = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FOUND     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                act;
        t_op                 op;
        logic [ADDR_W-1:0]   peer;
        logic [CHAN_W-1:0]   chan;
        logic [TIME_W-1:0]   exp_new;
        logic                done;
        t_status             status;
        logic [ADDR_W-1:0]   res_peer;
        logic [CHAN_W-1:0]   res_chan;
        logic [TIME_W-1:0]   res_exp;
    } t_token;

endpackage

@@ design/relay_channel_binding_table.sv @@
// Top level: request capture, expiry computation, cell chain and result register.
// A request passes the states S_MUL, S_ADD and S_SCAN before its result is held in S_OUT.
// Only one request is in flight at a time; the request walks the cell chain,
// one cell per cycle, before the next request is taken.
// Reset: synchronous active low; empties the table (count zero), lifetime back to 600 s.
// Entry contents are not cleared; only entries below the count are ever compared.
module relay_channel_binding_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [47:0] i_peer_address,
    input  logic [15:0] i_channel_number,
    input  logic [47:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [47:0] o_found_peer,
    output logic [15:0] o_found_channel,
    output logic [47:0] o_expiry_ms,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N = rcbt_pkg::MAX_BINDINGS;

    rcbt_pkg::t_state                r_state;
    rcbt_pkg::t_state                n_state;
    logic [rcbt_pkg::CNT_W-1:0]      r_count;
    logic [rcbt_pkg::LIFE_W-1:0]     r_life;
    rcbt_pkg::t_op                   r_op;
    logic [rcbt_pkg::ADDR_W-1:0]     r_peer;
    logic [rcbt_pkg::CHAN_W-1:0]     r_chan;
    logic [rcbt_pkg::TIME_W-1:0]     r_now;
    logic [rcbt_pkg::PROD_W-1:0]     r_prod;
    rcbt_pkg::t_status               r_status;
    logic [rcbt_pkg::ADDR_W-1:0]     r_res_peer;
    logic [rcbt_pkg::CHAN_W-1:0]     r_res_chan;
    logic [rcbt_pkg::TIME_W-1:0]     r_res_exp;
    logic [rcbt_pkg::TIME_W:0]       exp_sum;
    logic [rcbt_pkg::TIME_W-1:0]     exp_sat;
    rcbt_pkg::t_token                head_tok;
    rcbt_pkg::t_token                w_tok [N+1];
    logic [N-1:0]                    entry_valid;
    logic [N-1:0]                    tok_act;
    rcbt_pkg::t_token                last_tok;
    logic                            in_acc;
    logic                            out_acc;
    logic                            cfg_wr;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign cfg_wr  = psel && penable && pwrite && pready && !paddr[2];
    assign pready  = 1'b1;
    assign prdata  = paddr[2] ? 32'd0 : 32'(r_life);

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life <= rcbt_pkg::LIFE_W'(rcbt_pkg::LIFE_RESET);
        end else if (cfg_wr) begin
            r_life <= pwdata[rcbt_pkg::LIFE_W-1:0];
        end
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcbt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            rcbt_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = rcbt_pkg::S_MUL;
                end
            end
            rcbt_pkg::S_MUL: n_state = rcbt_pkg::S_ADD;
            rcbt_pkg::S_ADD: n_state = rcbt_pkg::S_SCAN;
            rcbt_pkg::S_SCAN: begin
                if (last_tok.act) begin
                    n_state = rcbt_pkg::S_OUT;
                end
            end
            rcbt_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = rcbt_pkg::S_IDLE;
                end
            end
            default: n_state = rcbt_pkg::S_IDLE;
        endcase
    end

    // request capture and expiry product
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= rcbt_pkg::t_op'(i_op);
            r_peer <= i_peer_address;
            r_chan <= i_channel_number;
            r_now  <= i_now_ms;
        end
        if (r_state == rcbt_pkg::S_MUL) begin
            r_prod <= rcbt_pkg::PROD_W'(r_life)
                    * rcbt_pkg::PROD_W'(rcbt_pkg::MS_PER_SECOND);
        end
    end

    assign exp_sum = {1'b0, r_now} + (rcbt_pkg::TIME_W + 1)'(r_prod);
    assign exp_sat = exp_sum[rcbt_pkg::TIME_W] ? '1 : exp_sum[rcbt_pkg::TIME_W-1:0];

    // request token into the head of the chain
    always_comb begin
        head_tok          = '0;
        head_tok.act      = (r_state == rcbt_pkg::S_ADD);
        head_tok.op       = r_op;
        head_tok.peer     = r_peer;
        head_tok.chan     = r_chan;
        head_tok.exp_new  = exp_sat;
        head_tok.done     = (r_op == rcbt_pkg::OP_NONE);
        head_tok.status   = rcbt_pkg::ST_NOT_FOUND;
    end

    assign w_tok[0] = head_tok;

    for (genvar g = 0; g < N; g++) begin : g_cell
        assign entry_valid[g] = (rcbt_pkg::CNT_W'(g) < r_count);
        assign tok_act[g]     = w_tok[g+1].act;
        rcbt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_entry_valid (entry_valid[g]),
            .i_tok         (w_tok[g]),
            .o_tok         (w_tok[g+1])
        );
    end

    assign last_tok = w_tok[N];

    // result register and table fill count
    always_ff @(posedge i_clk) begin
        if (r_state == rcbt_pkg::S_SCAN && last_tok.act) begin
            if (last_tok.done) begin
                r_status   <= last_tok.status;
                r_res_peer <= last_tok.res_peer;
                r_res_chan <= last_tok.res_chan;
                r_res_exp  <= last_tok.res_exp;
            end else begin
                r_status   <= (last_tok.op == rcbt_pkg::OP_BIND) ? rcbt_pkg::ST_FULL
                                                                 : rcbt_pkg::ST_NOT_FOUND;
                r_res_peer <= '0;
                r_res_chan <= '0;
                r_res_exp  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == rcbt_pkg::S_SCAN && last_tok.act && last_tok.done
                     && last_tok.status == rcbt_pkg::ST_ADDED) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign o_status        = r_status;
    assign o_found_peer    = r_res_peer;
    assign o_found_channel = r_res_chan;
    assign o_expiry_ms     = r_res_exp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rcbt_pkg::CNT_W'(N))
        else $error("binding count beyond table size");

    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_act))
        else $error("more than one request in the cell chain");

    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_tok.act |-> r_state == rcbt_pkg::S_SCAN)
        else $error("request left the chain outside the scan phase");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1
                                         && o_valid && o_status == rcbt_pkg::ST_ADDED))
        else $error("count changed without an added binding");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready && !o_valid)
        else $error("block idle right after taking a request");

endmodule

@@ design/rcbt_cell.sv @@
// One binding entry: compares the passing request, updates itself, forwards the request.
module rcbt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_entry_valid,
    input  rcbt_pkg::t_token  i_tok,
    output rcbt_pkg::t_token  o_tok
);

    logic [rcbt_pkg::ADDR_W-1:0] r_peer;
    logic [rcbt_pkg::CHAN_W-1:0] r_chan;
    logic [rcbt_pkg::TIME_W-1:0] r_exp;
    rcbt_pkg::t_token            r_tok;
    rcbt_pkg::t_token            n_tok;
    logic                        chan_hit;
    logic                        peer_hit;
    logic                        wr_exp;
    logic                        wr_all;

    assign chan_hit = i_entry_valid && (r_chan == i_tok.chan);
    assign peer_hit = i_entry_valid && (r_peer == i_tok.peer);

    always_comb begin
        n_tok  = i_tok;
        wr_exp = 1'b0;
        wr_all = 1'b0;
        if (i_tok.act && !i_tok.done) begin
            unique case (i_tok.op)
                rcbt_pkg::OP_BIND: begin
                    if (chan_hit) begin
                        n_tok.done = 1'b1;
                        if (peer_hit) begin
                            n_tok.status   = rcbt_pkg::ST_REFRESHED;
                            n_tok.res_peer = r_peer;
                            n_tok.res_chan = r_chan;
                            n_tok.res_exp  = i_tok.exp_new;
                            wr_exp         = 1'b1;
                        end else begin
                            n_tok.status = rcbt_pkg::ST_IN_USE;
                        end
                    end else if (peer_hit) begin
                        n_tok.done   = 1'b1;
                        n_tok.status = rcbt_pkg::ST_IN_USE;
                    end else if (!i_entry_valid) begin
                        // first free slot, nothing bound before it
                        n_tok.done     = 1'b1;
                        n_tok.status   = rcbt_pkg::ST_ADDED;
                        n_tok.res_peer = i_tok.peer;
                        n_tok.res_chan = i_tok.chan;
                        n_tok.res_exp  = i_tok.exp_new;
                        wr_all         = 1'b1;
                    end
                end
                rcbt_pkg::OP_LOOKUP_CH: begin
                    if (chan_hit) begin
                        n_tok.done     = 1'b1;
                        n_tok.status   = rcbt_pkg::ST_FOUND;
                        n_tok.res_peer = r_peer;
                        n_tok.res_chan = r_chan;
                        n_tok.res_exp  = r_exp;
                    end
                end
                rcbt_pkg::OP_LOOKUP_PEER: begin
                    if (peer_hit) begin
                        n_tok.done     = 1'b1;
                        n_tok.status   = rcbt_pkg::ST_FOUND;
                        n_tok.res_peer = r_peer;
                        n_tok.res_chan = r_chan;
                        n_tok.res_exp  = r_exp;
                    end
                end
                rcbt_pkg::OP_NONE: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_all) begin
            r_peer <= i_tok.peer;
            r_chan <= i_tok.chan;
        end
        if (wr_all || wr_exp) begin
            r_exp <= i_tok.exp_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
